### rtl/cesd_pkg.sv
// Shared types, constants and character helpers for the escape sequence decoder.
package cesd_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned LEN_OUT_BITS = 16;
  localparam int unsigned MAX_RES = 3;

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_OCT1    = 3'd2,
    PH_OCT2    = 3'd3,
    PH_HEX1_LO = 3'd4,
    PH_HEX1_UP = 3'd5,
    PH_HEX2_LO = 3'd6,
    PH_HEX2_UP = 3'd7
  } esc_phase_e;

  typedef struct packed {
    esc_phase_e             phase;
    logic [7:0]             acc;
    logic [7:0]             held;
    logic [LENGTH_BITS-1:0] cnt;
  } esc_state_t;

  typedef struct packed {
    logic [1:0]              n;
    logic [MAX_RES-1:0][7:0] bytes;
    logic                    has_end;
    logic                    cut;
    logic [LEN_OUT_BITS-1:0] len;
  } step_res_t;

  function automatic logic is_dec(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (is_dec(c)) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Returns the valid flag in bit 8 and the decoded character below it.
  function automatic logic [8:0] simple_esc(logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_OUT_BITS-1:0] sat_len(logic [LENGTH_BITS-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    return (w > 33'h0FFFF) ? '1 : w[LEN_OUT_BITS-1:0];
  endfunction

endpackage

### rtl/cesd_step.sv
// Combinational decode of one source byte against the current escape state.
module cesd_step (
  input  cesd_pkg::esc_state_t st_i,
  input  logic [7:0]           byte_i,
  output cesd_pkg::esc_state_t st_o,
  output cesd_pkg::step_res_t  res_o
);
  import cesd_pkg::*;

  logic [MAX_RES-1:0][7:0] eb;
  logic [1:0]              e_n;
  logic                    do_end;
  logic                    cut;
  logic                    plain;
  logic [8:0]              se;
  logic [7:0]              oct;
  logic [7:0]              letter;
  logic [LENGTH_BITS:0]    sum;
  logic [LENGTH_BITS-1:0]  cnt_sat;
  esc_phase_e              ph_n;
  logic [7:0]              acc_n;
  logic [7:0]              held_n;

  assign se  = simple_esc(byte_i);
  assign oct = {st_i.acc[4:0], 3'b000} | (byte_i - CH_ZERO);
  assign letter = (st_i.phase == PH_HEX1_LO || st_i.phase == PH_HEX2_LO) ? CH_LX : CH_UX;

  always_comb begin
    eb     = '0;
    e_n    = 2'd0;
    do_end = 1'b0;
    cut    = 1'b0;
    plain  = 1'b0;
    ph_n   = PH_IDLE;
    acc_n  = st_i.acc;
    held_n = st_i.held;
    unique case (st_i.phase)
      PH_IDLE: begin
        plain = 1'b1;
      end
      PH_ESC: begin
        if (is_dec(byte_i)) begin
          acc_n = byte_i - CH_ZERO;
          ph_n  = PH_OCT1;
        end else if (se[8]) begin
          eb[0] = se[7:0];
          e_n   = 2'd1;
        end else if (byte_i == CH_LX) begin
          ph_n = PH_HEX1_LO;
        end else if (byte_i == CH_UX) begin
          ph_n = PH_HEX1_UP;
        end else begin
          plain = 1'b1;
        end
      end
      PH_OCT1: begin
        if (byte_i == CH_NUL) begin
          do_end = 1'b1;
          cut    = 1'b1;
        end else begin
          acc_n = oct;
          ph_n  = PH_OCT2;
        end
      end
      PH_OCT2: begin
        if (byte_i == CH_NUL) begin
          do_end = 1'b1;
          cut    = 1'b1;
        end else begin
          acc_n = oct;
          eb[0] = oct;
          e_n   = 2'd1;
        end
      end
      PH_HEX1_LO, PH_HEX1_UP: begin
        if (is_hex(byte_i)) begin
          held_n = byte_i;
          ph_n   = (st_i.phase == PH_HEX1_LO) ? PH_HEX2_LO : PH_HEX2_UP;
        end else begin
          eb[0] = letter;
          e_n   = 2'd1;
          plain = 1'b1;
        end
      end
      PH_HEX2_LO, PH_HEX2_UP: begin
        if (is_hex(byte_i) && is_hex(st_i.held)) begin
          eb[0] = {hex_val(st_i.held), hex_val(byte_i)};
          e_n   = 2'd1;
        end else if (is_dec(st_i.held)) begin
          eb[0] = st_i.held - CH_ZERO;
          e_n   = 2'd1;
          plain = 1'b1;
        end else begin
          eb[0] = letter;
          eb[1] = st_i.held;
          e_n   = 2'd2;
          plain = 1'b1;
        end
      end
    endcase

    if (plain) begin
      if (byte_i == CH_NUL) begin
        do_end = 1'b1;
      end else if (byte_i == CH_BSL) begin
        ph_n = PH_ESC;
      end else begin
        unique case (e_n)
          2'd0:    eb[0] = byte_i;
          2'd1:    eb[1] = byte_i;
          default: eb[2] = byte_i;
        endcase
        e_n = e_n + 2'd1;
      end
    end

    if (do_end) begin
      ph_n   = PH_IDLE;
      acc_n  = '0;
      held_n = '0;
    end
  end

  assign sum     = {1'b0, st_i.cnt} + (LENGTH_BITS+1)'(e_n);
  assign cnt_sat = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[LENGTH_BITS-1:0];

  assign st_o          = '{phase: ph_n, acc: acc_n, held: held_n,
                           cnt: (do_end ? '0 : cnt_sat)};
  assign res_o.n       = e_n + {1'b0, do_end};
  assign res_o.bytes   = eb;
  assign res_o.has_end = do_end;
  assign res_o.cut     = cut;
  assign res_o.len     = sat_len(cnt_sat);

endmodule

### rtl/c_escape_sequence_decoder_core.sv
// Top level of the C string escape decoder: input register, decode step, result buffer.
//
// The input channel carries one source byte per item; a zero byte ends the
// string. The output channel carries decoded bytes, and for each terminator
// one end item with is_end set, the decoded length of the string and the
// escape_cut flag. Each input item causes zero to three output items, and
// last marks the final one caused by that input.
// An accepted byte sits in the input register until the result buffer is free,
// is decoded in one pass and loaded into a three-entry result buffer; its
// results are offered on the output from that buffer. While the output is
// not stalled the buffer drains one item per cycle, so an input that causes
// one result sustains one item per cycle, and an input that causes several
// results holds the next input back until its last result is taken. Inputs
// that cause no result leave the buffer empty.
// While the output is stalled the buffer holds its items and the input
// register fills, after which in_stall_o rises. A new item is taken while
// the last result of the previous one is being handed over.
// Reset clears the escape state and the length count and empties the input
// register and the result buffer; the data they hold is not reset.
module c_escape_sequence_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  src_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_end_o,
  output logic [15:0] decoded_length_o,
  output logic        escape_cut_o,
  output logic        last_o
);
  import cesd_pkg::*;

  logic                    in_vld_q, in_vld_d;
  logic [7:0]              in_byte_q;
  esc_state_t              st_q, st_d;
  step_res_t               res;
  logic [1:0]              rem_q, rem_d;
  logic [1:0]              hd_q, hd_d;
  logic [MAX_RES-1:0][7:0] byte_q;
  logic                    end_q;
  logic                    cut_q;
  logic [LEN_OUT_BITS-1:0] len_q;
  logic                    in_fire;
  logic                    out_fire;
  logic                    buf_free;
  logic                    consume;

  cesd_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  assign out_valid_o = (rem_q != 2'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign buf_free    = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_fire);
  assign consume     = in_vld_q && buf_free;
  assign in_stall_o  = in_vld_q && !buf_free;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (consume) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    rem_d = rem_q;
    hd_d  = hd_q;
    if (consume) begin
      rem_d = res.n;
      hd_d  = 2'd0;
    end else if (out_fire) begin
      rem_d = rem_q - 2'd1;
      hd_d  = hd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= '{phase: PH_IDLE, acc: '0, held: '0, cnt: '0};
      rem_q    <= 2'd0;
      hd_q     <= 2'd0;
    end else begin
      in_vld_q <= in_vld_d;
      rem_q    <= rem_d;
      hd_q     <= hd_d;
      if (consume) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= src_byte_i;
    end
    if (consume) begin
      byte_q <= res.bytes;
      end_q  <= res.has_end;
      cut_q  <= res.cut;
      len_q  <= res.len;
    end
  end

  always_comb begin
    unique case (hd_q)
      2'd0:    out_byte_o = byte_q[0];
      2'd1:    out_byte_o = byte_q[1];
      default: out_byte_o = byte_q[2];
    endcase
  end

  assign last_o           = (rem_q == 2'd1);
  assign is_end_o         = end_q && last_o;
  assign decoded_length_o = is_end_o ? len_q : '0;
  assign escape_cut_o     = is_end_o && cut_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, hd_q} + {1'b0, rem_q}) <= 3'd3))
    else $error("result buffer read past its last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |-> ((rem_q == 2'd0) || out_fire))
    else $error("result buffer overwritten while items remain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && res.has_end) |=> (st_q.cnt == '0 && st_q.phase == PH_IDLE))
    else $error("terminator did not clear the string state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && res.cut) |-> res.has_end)
    else $error("escape cut flagged without an end item");

endmodule
